### sv/pfd_pkg.sv
// Shared types, constants and saturation helpers for the filtered-derivative PID block.
// No dependencies; every other file imports this package.
package pfd_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int CFG_IDX_W     = 8;
	localparam int MUL_W         = DATA_W + 1;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int SAT_W         = PROD_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 8'd0,
		REG_INTEG_GAIN  = 8'd1,
		REG_DERIV_GAIN  = 8'd2,
		REG_INTEG_LOW   = 8'd3,
		REG_INTEG_HIGH  = 8'd4,
		REG_DRIVE_LOW   = 8'd5,
		REG_DRIVE_HIGH  = 8'd6,
		REG_CUTOFF_RATE = 8'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] prop_gain;
		logic signed [DATA_W-1:0] integ_gain;
		logic signed [DATA_W-1:0] deriv_gain;
		logic signed [DATA_W-1:0] integ_low;
		logic signed [DATA_W-1:0] integ_high;
		logic signed [DATA_W-1:0] drive_low;
		logic signed [DATA_W-1:0] drive_high;
		logic        [DATA_W-2:0] cutoff_rate;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-DATA_W:0] top;
		top = v[SAT_W-1:DATA_W-1];
		if ((&top) || !(|top)) begin
			return v[DATA_W-1:0];
		end
		return v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	// Apply the high limit first, then the low limit, so a crossed pair yields low.
	function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [DATA_W-1:0] v,
			input logic signed [DATA_W-1:0] lo, input logic signed [DATA_W-1:0] hi);
		logic signed [DATA_W-1:0] r;
		r = (v > hi) ? hi : v;
		r = (r < lo) ? lo : r;
		return r;
	endfunction

endpackage

### sv/pfd_if.sv
// Valid/ready channel interfaces for the filtered-derivative PID block.
// Depends on pfd_pkg for widths.
interface pfd_in_if import pfd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic signed [DATA_W-1:0] reference;
	logic signed [DATA_W-1:0] measurement;
	logic        [DATA_W-1:0] timestamp;
	modport source (output valid, action, reference, measurement, timestamp, input ready);
	modport sink (input valid, action, reference, measurement, timestamp, output ready);
endinterface

interface pfd_out_if import pfd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic signed [DATA_W-1:0] error_out;
	modport source (output valid, drive, error_out, input ready);
	modport sink (input valid, drive, error_out, output ready);
endinterface

interface pfd_cfg_if import pfd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/pfd_cfg.sv
// Configuration register file: gains, clamps and filter cutoff.
// Depends on pfd_pkg and pfd_cfg_if.
module pfd_cfg import pfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pfd_cfg_if.sink    cfg_ch,
	output cfg_t       cfg
);

	cfg_t regs_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg           = regs_q;

	// Write the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.prop_gain   <= '0;
			regs_q.integ_gain  <= '0;
			regs_q.deriv_gain  <= '0;
			regs_q.integ_low   <= {1'b1, {(DATA_W-1){1'b0}}};
			regs_q.integ_high  <= {1'b0, {(DATA_W-1){1'b1}}};
			regs_q.drive_low   <= {1'b1, {(DATA_W-1){1'b0}}};
			regs_q.drive_high  <= {1'b0, {(DATA_W-1){1'b1}}};
			regs_q.cutoff_rate <= '0;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_PROP_GAIN:   regs_q.prop_gain   <= cfg_ch.data;
				REG_INTEG_GAIN:  regs_q.integ_gain  <= cfg_ch.data;
				REG_DERIV_GAIN:  regs_q.deriv_gain  <= cfg_ch.data;
				REG_INTEG_LOW:   regs_q.integ_low   <= cfg_ch.data;
				REG_INTEG_HIGH:  regs_q.integ_high  <= cfg_ch.data;
				REG_DRIVE_LOW:   regs_q.drive_low   <= cfg_ch.data;
				REG_DRIVE_HIGH:  regs_q.drive_high  <= cfg_ch.data;
				REG_CUTOFF_RATE: regs_q.cutoff_rate <= cfg_ch.data[DATA_W-2:0];
				default: ;
			endcase
		end
	end

endmodule

### sv/pfd_mul.sv
// Shared registered 33x33 signed multiplier.
// Depends on pfd_pkg for widths.
module pfd_mul import pfd_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// Register the product; the sequencer reads it in the cycle after issue
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

### sv/pfd_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pfd_pkg for widths and the status struct.
module pfd_div import pfd_pkg::*; #(
	parameter int DW = DATA_W + 1 + FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic [DW-1:0]     quotient,
	output div_stat_t         stat
);

	localparam int CW = $clog2(DW + 1);

	logic [DATA_W-1:0] rem_q;
	logic [DW-1:0]     quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              ge;

	// Trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### sv/pid_filtered_derivative_clamped.sv
// PID controller step with low-pass filtered derivative, fixed point Q(32-F).F.
// Depends on pfd_pkg, pfd_if, pfd_cfg, pfd_mul and pfd_div.
//
// Use: in_ch carries action, reference, measurement and timestamp; a control
// step (action 0) yields one transaction on out_ch with drive and error_out,
// a restart (action 1) only records the timestamp and yields nothing.
// cfg_ch writes the eight registers by index and is always ready; write it
// only while the block is idle.
// A restart leaves the block idle and ready. A control step is paced by two
// passes through the bit-serial divider, one bit a cycle, plus seven issues
// of the shared multiplier. in_ch.ready is low for the whole step, so the
// block takes no new item until the step has put its result in the output
// register.
// The result sits in an output register: when the receiver stalls it holds,
// and the next item is still taken; a step that finishes while the previous
// result waits holds in its last state until that result is taken.
// Reset clears the state (previous time, integral, previous error, filtered
// derivative), loads the register defaults and empties the output register.
module pid_filtered_derivative_clamped import pfd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pfd_in_if.sink    in_ch,
	pfd_out_if.source out_ch,
	pfd_cfg_if.sink   cfg_ch
);

	localparam int                DW     = DATA_W + 1 + FRAC_BITS;
	localparam logic [DATA_W-1:0] ONE    = DATA_W'(64'd1 << FRAC_BITS);
	localparam logic [DATA_W-1:0] DT_MIN = DATA_W'((64'd1 << FRAC_BITS) / 64'd1000000);
	localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_EDT, ST_WDT, ST_WDTR, ST_DIV1, ST_DIV2, ST_AD,
		ST_OF, ST_DSUM, ST_KI, ST_KD, ST_Y, ST_OUT
	} state_t;

	state_t                   state_q;
	cfg_t                     cfg;
	logic [DATA_W-1:0]        prev_time_q;
	logic signed [DATA_W-1:0] integral_q;
	logic signed [DATA_W-1:0] prev_error_q;
	logic signed [DATA_W-1:0] fd_q;
	logic [DATA_W-1:0]        dt_q;
	logic signed [DATA_W-1:0] e_q;
	logic signed [DATA_W-1:0] i_q;
	logic signed [DATA_W-1:0] draw_q;
	logic [DATA_W-2:0]        wdt_q;
	logic [FRAC_BITS:0]       alpha_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [DATA_W-1:0] d_q;
	logic signed [DATA_W+1:0] y_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic signed [DATA_W-1:0] err_out_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [DATA_W-1:0] prod_sat;
	logic                     div_start;
	logic [DW-1:0]            div_dividend;
	logic [DATA_W-1:0]        div_divisor;
	logic [DW-1:0]            quotient;
	div_stat_t                div_stat;

	logic                     in_acc;
	logic                     out_free;
	logic signed [DATA_W:0]   e_raw;
	logic signed [DATA_W+1:0] de;
	logic [DATA_W:0]          de_mag;
	logic                     de_neg;
	logic [FRAC_BITS:0]       one_m_alpha;
	logic signed [DATA_W-1:0] draw_sat;
	logic                     q_big_pos;
	logic                     q_big_neg;
	logic signed [SAT_W-1:0]  i_sum;
	logic signed [SAT_W-1:0]  d_sum;
	logic signed [DATA_W-1:0] y_fin;

	pfd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	pfd_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	pfd_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.stat     (div_stat)
	);

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign in_acc           = in_ch.valid && (state_q == ST_IDLE);
	assign out_free         = !out_valid_q || out_ch.ready;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.drive     = drive_q;
	assign out_ch.error_out = err_out_q;

	// Error of the incoming item and error change against the previous step
	assign e_raw       = {in_ch.reference[DATA_W-1], in_ch.reference}
		- {in_ch.measurement[DATA_W-1], in_ch.measurement};
	assign de          = (DATA_W+2)'(e_q) - (DATA_W+2)'(prev_error_q);
	assign de_neg      = de[DATA_W+1];
	assign de_mag      = de_neg ? (DATA_W+1)'(-de) : de[DATA_W:0];
	assign one_m_alpha = ONE[FRAC_BITS:0] - alpha_q;

	// Product scaled back to the fixed-point grid and saturated
	assign prod_sh  = prod >>> FRAC_BITS;
	assign prod_sat = sat32(SAT_W'(prod_sh));
	assign i_sum    = SAT_W'(integral_q) + SAT_W'(prod_sh);
	assign d_sum    = SAT_W'(acc_q) + SAT_W'(prod);
	assign y_fin    = clamp32(sat32(SAT_W'(y_q) + SAT_W'(prod_sat)),
		cfg.drive_low, cfg.drive_high);

	// Saturate the signed quotient of the raw derivative
	assign q_big_pos = (|quotient[DW-1:DATA_W-1]);
	assign q_big_neg = (|quotient[DW-1:DATA_W]) ||
		(quotient[DATA_W-1] && (|quotient[DATA_W-2:0]));
	always_comb begin
		if (de_neg) begin
			draw_sat = q_big_neg ? S_MIN : -$signed(quotient[DATA_W-1:0]);
		end else begin
			draw_sat = q_big_pos ? S_MAX : $signed(quotient[DATA_W-1:0]);
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		case (state_q)
			ST_EDT: begin
				mul_a = MUL_W'(e_q);
				mul_b = $signed({1'b0, dt_q});
			end
			ST_WDT: begin
				mul_a = $signed({2'b00, cfg.cutoff_rate});
				mul_b = $signed({1'b0, dt_q});
			end
			ST_AD: begin
				mul_a = $signed({{(MUL_W-FRAC_BITS-1){1'b0}}, alpha_q});
				mul_b = MUL_W'(draw_q);
			end
			ST_OF: begin
				mul_a = $signed({{(MUL_W-FRAC_BITS-1){1'b0}}, one_m_alpha});
				mul_b = MUL_W'(fd_q);
			end
			ST_DSUM: begin
				mul_a = MUL_W'(cfg.prop_gain);
				mul_b = MUL_W'(e_q);
			end
			ST_KI: begin
				mul_a = MUL_W'(cfg.integ_gain);
				mul_b = MUL_W'(i_q);
			end
			ST_KD: begin
				mul_a = MUL_W'(cfg.deriv_gain);
				mul_b = MUL_W'(d_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Launch the derivative division, then the filter-coefficient division
	always_comb begin
		div_start    = (state_q == ST_WDTR) || ((state_q == ST_DIV1) && div_stat.done);
		div_dividend = DW'(de_mag) << FRAC_BITS;
		div_divisor  = dt_q;
		if (state_q != ST_WDTR) begin
			div_dividend = DW'(wdt_q) << FRAC_BITS;
			div_divisor  = ONE + DATA_W'(wdt_q);
		end
	end

	// Sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_time_q  <= '0;
			integral_q   <= '0;
			prev_error_q <= '0;
			fd_q         <= '0;
			dt_q         <= '0;
			e_q          <= '0;
			i_q          <= '0;
			draw_q       <= '0;
			wdt_q        <= '0;
			alpha_q      <= '0;
			acc_q        <= '0;
			d_q          <= '0;
			y_q          <= '0;
			out_valid_q  <= 1'b0;
			drive_q      <= '0;
			err_out_q    <= '0;
		end else begin
			if (out_valid_q && out_ch.ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						prev_time_q <= in_ch.timestamp;
						if (!in_ch.action) begin
							dt_q    <= in_ch.timestamp - prev_time_q;
							e_q     <= sat32(SAT_W'(e_raw));
							state_q <= ST_EDT;
						end
					end
				end
				ST_EDT: state_q <= ST_WDT;
				ST_WDT: begin
					i_q     <= clamp32(sat32(i_sum), cfg.integ_low, cfg.integ_high);
					state_q <= ST_WDTR;
				end
				ST_WDTR: begin
					wdt_q   <= (|prod[PROD_W-1:DATA_W-1+FRAC_BITS]) ? {(DATA_W-1){1'b1}}
						: prod[DATA_W-2+FRAC_BITS:FRAC_BITS];
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_stat.done) begin
						draw_q  <= (dt_q > DT_MIN) ? draw_sat : '0;
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_stat.done) begin
						alpha_q <= quotient[FRAC_BITS:0];
						state_q <= ST_AD;
					end
				end
				ST_AD: state_q <= ST_OF;
				ST_OF: begin
					acc_q   <= prod;
					state_q <= ST_DSUM;
				end
				ST_DSUM: begin
					d_q     <= sat32(d_sum >>> FRAC_BITS);
					state_q <= ST_KI;
				end
				ST_KI: begin
					y_q     <= (DATA_W+2)'(prod_sat);
					state_q <= ST_KD;
				end
				ST_KD: begin
					y_q     <= y_q + (DATA_W+2)'(prod_sat);
					state_q <= ST_Y;
				end
				ST_Y: begin
					integral_q   <= i_q;
					prev_error_q <= e_q;
					fd_q         <= d_q;
					y_q          <= (DATA_W+2)'(y_fin);
					state_q      <= ST_OUT;
				end
				// Hold the finished drive until the output register is free
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						drive_q     <= y_q[DATA_W-1:0];
						err_out_q   <= e_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/pfd_check.sv
// Port-level checker for the filtered-derivative PID block, bound to the top level.
// Depends on pfd_pkg for widths.
module pfd_check import pfd_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     in_action,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] out_drive
);

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_drive))
		else $error("result dropped or changed while stalled");

	// A control step keeps the block busy in the cycle after it is taken
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_action |=> !in_ready)
		else $error("input taken again right after a control step");

	// After a restart the block is ready again in the next cycle
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_action |=> in_ready)
		else $error("restart left the block busy");

	// No result appears right after a control step is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_action && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind pid_filtered_derivative_clamped pfd_check u_pfd_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_action (in_ch.action),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_drive (out_ch.drive)
);
